FILE: rtl/vkt_pkg.sv
// package for the versioned key table
// types, opcodes, status codes and sizes; no dependencies
package vkt_pkg;
  localparam int CAPACITY = 32;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOKEY  = 2'd2;

  typedef struct packed {
    logic [31:0]        key;
    logic signed [15:0] rel;
    logic [15:0]        info;
  } entry_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic        shift;   // cells at or above pos take the upstream entry
    logic [IW:0] pos;
    logic        load;    // write new entry at pos
    entry_t      wr;
  } cell_ctl_t;
endpackage

FILE: rtl/vkt_cell.sv
// one table cell: holds an entry and can take its upper neighbor's entry
// depends on vkt_pkg
module vkt_cell import vkt_pkg::*; (
  input  logic       clk,
  input  logic [IW:0] idx,
  input  cell_ctl_t  ctl,
  input  entry_t     up_in,
  output entry_t     ent
);
  entry_t ent_r;
  assign ent = ent_r;
  always_ff @(posedge clk) begin
    if (ctl.load && ctl.pos == idx) begin
      ent_r <= ctl.wr;
    end else if (ctl.shift && idx >= ctl.pos) begin
      ent_r <= up_in;
    end
  end
endmodule

FILE: rtl/versioned_key_table_top.sv
// versioned key table: scan sequencer over a row of entry cells
// each op but the unused one scans the stored entries in order; most results come from a done state after it
// a first-match find returns on its hit; a find of all releases holds one match back
// so that last lands on the final one; a waiting output holds a find's scan at a match
// one transaction at a time: in_ready is high only in idle with the output free
// reset: synchronous active-low rst_n empties the table; cell contents are not cleared
module versioned_key_table_top import vkt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_key,
  input  logic signed [15:0] in_release_select,
  input  logic [15:0]        in_info_handle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_found_key,
  output logic signed [15:0] out_found_release,
  output logic [15:0]        out_found_info,
  output logic [5:0]         out_removed_count,
  output logic               out_last
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
  state_t state_r;

  entry_t cells [CAPACITY];
  entry_t ups [CAPACITY];
  cell_ctl_t ctl;

  logic [1:0]  op_r;
  entry_t      req_r;
  logic [IW:0] cnt_r, ptr_r;
  logic [CW-1:0] rem_r;
  logic signed [15:0] best_r;
  entry_t      pend_r;   // match held back until the next one or the end
  logic        pend_v_r;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == CAPACITY - 1) begin : g_top
        assign ups[g] = cells[g];
      end else begin : g_mid
        assign ups[g] = cells[g+1];
      end
      vkt_cell u_cell (.clk(clk), .idx((IW+1)'(g)), .ctl(ctl), .up_in(ups[g]),
                       .ent(cells[g]));
    end
  endgenerate

  entry_t cur;
  logic   at_end, keym, relm, match;
  assign at_end = (ptr_r >= cnt_r);
  assign cur    = cells[ptr_r[IW-1:0]];
  assign keym   = cur.key == req_r.key;
  assign relm   = (cur.rel == req_r.rel) || (req_r.rel == 16'sd0);
  assign match  = !at_end && keym && relm;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;

  logic first_only;
  assign first_only = req_r.rel != 16'sd0;

  logic emit_scan, emit_done;
  assign emit_scan = (state_r == S_SCAN) && (op_r == OP_FIND) && match && out_free &&
                     (first_only || pend_v_r);
  assign emit_done = (state_r == S_DONE) && out_free;

  always_comb begin
    ctl = '0;
    ctl.pos = ptr_r;
    ctl.wr  = req_r;
    if (state_r == S_SCAN && op_r == OP_DELETE && match &&
        (!first_only || rem_r == '0)) begin
      ctl.shift = 1'b1;
    end
    if (state_r == S_DONE && op_r == OP_INSERT && cnt_r < (IW+1)'(CAPACITY)) begin
      ctl.load = 1'b1;
      ctl.pos  = cnt_r;
      if (req_r.rel == -16'sd1)
        ctl.wr.rel = (best_r == 16'sd32767) ? best_r : best_r + 16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_scan || emit_done || (out_valid && !out_ready);
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          op_r     <= in_opcode;
          req_r    <= '{key: in_key, rel: in_release_select, info: in_info_handle};
          ptr_r    <= '0;
          rem_r    <= '0;
          pend_v_r <= 1'b0;
          best_r   <= '0;
          state_r  <= (in_opcode == OP_UNUSED) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          if (at_end) begin
            state_r <= S_DONE;
          end else if (op_r == OP_INSERT) begin
            if (keym && cur.rel > best_r) best_r <= cur.rel;
            ptr_r <= ptr_r + 1'b1;
          end else if (op_r == OP_DELETE) begin
            if (ctl.shift) begin
              rem_r <= rem_r + 1'b1;
              cnt_r <= cnt_r - 1'b1;
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end else if (match) begin
            if (first_only) begin
              if (out_free) begin
                out_status        <= ST_OK;
                out_found_key     <= cur.key;
                out_found_release <= cur.rel;
                out_found_info    <= cur.info;
                out_removed_count <= '0;
                out_last          <= 1'b1;
                state_r           <= S_IDLE;
              end
            end else if (!pend_v_r) begin
              pend_r   <= cur;
              pend_v_r <= 1'b1;
              ptr_r    <= ptr_r + 1'b1;
            end else if (out_free) begin
              // a later match exists, so the held one is not the last
              out_status        <= ST_OK;
              out_found_key     <= pend_r.key;
              out_found_release <= pend_r.rel;
              out_found_info    <= pend_r.info;
              out_removed_count <= '0;
              out_last          <= 1'b0;
              pend_r            <= cur;
              ptr_r             <= ptr_r + 1'b1;
            end
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_DONE: if (out_free) begin
          out_last <= 1'b1;
          state_r  <= S_IDLE;
          if (op_r == OP_INSERT) begin
            out_found_key     <= req_r.key;
            out_found_info    <= req_r.info;
            out_removed_count <= '0;
            if (ctl.load) begin
              out_status        <= ST_OK;
              out_found_release <= ctl.wr.rel;
              cnt_r             <= cnt_r + 1'b1;
            end else begin
              out_status        <= ST_FULL;
              out_found_release <= req_r.rel;
            end
          end else if (op_r == OP_DELETE) begin
            out_found_key     <= req_r.key;
            out_found_release <= req_r.rel;
            out_found_info    <= '0;
            out_removed_count <= 6'(rem_r);
            out_status        <= (rem_r != '0) ? ST_OK : ST_NOKEY;
          end else if (op_r == OP_FIND && pend_v_r) begin
            out_found_key     <= pend_r.key;
            out_found_release <= pend_r.rel;
            out_found_info    <= pend_r.info;
            out_removed_count <= '0;
            out_status        <= ST_OK;
          end else begin
            out_found_key     <= req_r.key;
            out_found_release <= req_r.rel;
            out_found_info    <= '0;
            out_removed_count <= '0;
            out_status        <= ST_NOKEY;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (IW+1)'(CAPACITY)) else $error("count over capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second transaction taken");
  a_shift_delete: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift |-> op_r == OP_DELETE) else $error("shift outside delete");
endmodule

FILE: test/tb_top.sv
// testbench for versioned_key_table_top: directed and random insert/delete/find traffic
// checked against a behavioral table model; depends on vkt_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import vkt_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic [31:0]        key;
    logic signed [15:0] rel;
    logic [15:0]        info;
    logic [5:0]         removed;
    logic               last;
  } table_result_t;

  class table_scoreboard;
    logic [31:0]        keys[$];
    logic signed [15:0] rels[$];
    logic [15:0]        infos[$];
    table_result_t      pending[$];
    int                 errors;

    function void push(logic [1:0] st, logic [31:0] k, logic signed [15:0] r,
                       logic [15:0] inf, logic [5:0] rm, logic lst);
      table_result_t t;
      t.status = st; t.key = k; t.rel = r; t.info = inf; t.removed = rm; t.last = lst;
      pending.push_back(t);
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] k, logic signed [15:0] r,
                               logic [15:0] inf);
      logic signed [15:0] best;
      int n;
      int i;
      bit hit;
      n = 0;
      if (op == OP_INSERT) begin
        if (keys.size() >= CAPACITY) begin
          push(ST_FULL, k, r, inf, 6'd0, 1'b1);
        end else begin
          if (r == -16'sd1) begin
            best = 16'sd0;
            foreach (keys[j]) if (keys[j] == k && rels[j] > best) best = rels[j];
            r = (best == 16'sh7fff) ? 16'sh7fff : best + 16'sd1;
          end
          keys.push_back(k); rels.push_back(r); infos.push_back(inf);
          push(ST_OK, k, r, inf, 6'd0, 1'b1);
        end
      end else if (op == OP_DELETE) begin
        i = 0;
        while (i < keys.size()) begin
          hit = keys[i] == k && (rels[i] == r || r == 0) && (r == 0 || n == 0);
          if (hit) begin
            keys.delete(i); rels.delete(i); infos.delete(i); n++;
          end else i++;
        end
        push(n ? ST_OK : ST_NOKEY, k, r, 16'h0, n[5:0], 1'b1);
      end else if (op == OP_FIND) begin
        foreach (keys[j]) begin
          if (keys[j] == k && (rels[j] == r || r == 0) && (r == 0 || n == 0)) begin
            push(ST_OK, keys[j], rels[j], infos[j], 6'd0, 1'b0);
            n++;
          end
        end
        if (n == 0) push(ST_NOKEY, k, r, 16'h0, 6'd0, 1'b1);
        else pending[pending.size() - 1].last = 1;
      end else begin
        push(ST_NOKEY, k, r, 16'h0, 6'd0, 1'b1);
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result key %h", got.key);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.key !== e.key) begin
        $error("found_key exp %h got %h", e.key, got.key); errors++;
      end
      if (got.rel !== e.rel) begin
        $error("found_release exp %0d got %0d", e.rel, got.rel); errors++;
      end
      if (got.info !== e.info) begin
        $error("found_info exp %h got %h", e.info, got.info); errors++;
      end
      if (got.removed !== e.removed) begin
        $error("removed_count exp %0d got %0d", e.removed, got.removed); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         in_opcode = 0;
  logic [31:0]        in_key = 0;
  logic signed [15:0] in_release_select = 0;
  logic [15:0]        in_info_handle = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [1:0]         out_status;
  logic [31:0]        out_found_key;
  logic signed [15:0] out_found_release;
  logic [15:0]        out_found_info;
  logic [5:0]         out_removed_count;
  logic               out_last;

  table_scoreboard sb = new();
  int  cycle_count;
  bit  hold_off;
  bit  quiet;
  bit  sender_done;
  logic [31:0] key_pool[4];

  versioned_key_table_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        table_result_t r;
        r.status = out_status; r.key = out_found_key; r.rel = out_found_release;
        r.info = out_found_info; r.removed = out_removed_count; r.last = out_last;
        sb.check_result(r);
      end
      if (hold_off) begin
        hold_off = 0;
        stall = 300;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 32);
    end
  end

  // valid stays up after acceptance until the next transaction or an idle cycle
  task automatic send(logic [1:0] op, logic [31:0] k, logic signed [15:0] r,
                      logic [15:0] inf);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_opcode <= op; in_key <= k;
    in_release_select <= r; in_info_handle <= inf;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, k, r, inf);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_item();
    logic [1:0] op;
    logic [31:0] k;
    logic signed [15:0] r;
    int p;
    p = $urandom_range(99);
    op = p < 50 ? OP_INSERT : (p < 70 ? OP_DELETE : (p < 97 ? OP_FIND : OP_UNUSED));
    k = $urandom_range(9) == 0 ? $urandom : key_pool[$urandom_range(3)];
    case ($urandom_range(5))
      0: r = -16'sd1;
      1: r = 16'sd0;
      2: r = 16'($urandom);
      default: r = 16'($urandom_range(4));
    endcase
    send(op, k, r, 16'($urandom));
  endtask

  initial begin
    key_pool[0] = 0; key_pool[1] = 32'hffffffff;
    key_pool[2] = $urandom; key_pool[3] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send(OP_FIND, 32'h0, 16'sd0, 16'h0);
    send(OP_DELETE, 32'h0, 16'sd0, 16'h0);
    send(OP_INSERT, 32'h0, -16'sd1, 16'h0);
    send(OP_INSERT, 32'h0, -16'sd1, 16'hffff);
    send(OP_INSERT, 32'hffffffff, 16'sh7fff, 16'h1234);
    send(OP_INSERT, 32'hffffffff, -16'sd1, 16'h5);
    send(OP_INSERT, 32'hffffffff, -16'sd1, 16'h6);
    send(OP_INSERT, 32'h7, -16'sd32768, 16'h7);
    send(OP_INSERT, 32'h7, 16'sd0, 16'h8);
    send(OP_INSERT, 32'h7, -16'sd1, 16'h9);
    send(OP_FIND, 32'hffffffff, 16'sd0, 16'h0);
    send(OP_FIND, 32'h0, 16'sd2, 16'h0);
    send(OP_FIND, 32'h7, -16'sd32768, 16'h0);
    send(OP_FIND, 32'h7, 16'sd5, 16'h0);
    send(OP_UNUSED, 32'h7, 16'sd1, 16'hffff);
    send(OP_DELETE, 32'h0, 16'sd1, 16'h0);
    send(OP_DELETE, 32'hffffffff, 16'sd0, 16'h0);
    send(OP_DELETE, 32'h7, 16'sd9, 16'h0);
    // fill to full and past it, then one more
    for (int i = 0; i < 30; i++) send(OP_INSERT, 32'h5, -16'sd1, i[15:0]);
    send(OP_INSERT, 32'h5, 16'sd3, 16'h1);
    send(OP_FIND, 32'h5, 16'sd0, 16'h0);
    send(OP_DELETE, 32'h5, -16'sd1, 16'h0);
    // long receiver stall while sender keeps going
    hold_off = 1;
    for (int i = 0; i < 10; i++) random_item();
    drain();
    send(OP_DELETE, 32'h5, 16'sd0, 16'h0);
    send(OP_DELETE, 32'h7, 16'sd0, 16'h0);
    for (int i = 0; i < 208; i++) begin
      quiet = i >= 100 && i < 140;
      if (i == 180) drain();
      random_item();
    end
    quiet = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/vkt_pkg.sv
rtl/vkt_cell.sv
rtl/versioned_key_table_top.sv
test/tb_top.sv
